@@ rtl/psr_pkg.sv @@
package psr_pkg;

  // input tdata layout, lowest bit first
  localparam int IN_TDATA_W = 208;
  localparam int OUT_TDATA_W = 8;
  localparam int CNT_LSB = 0;
  localparam int MAPV_BIT = 8;
  localparam int DIST_LSB = 9;
  localparam int MEAS_LSB = 41;
  localparam int NOW_LSB = 73;
  localparam int IDENT_LSB = 105;
  localparam int X_LSB = 121;
  localparam int Y_LSB = 153;
  localparam int COMP_LSB = 185;
  localparam int CONF_LSB = 193;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_CONF_FLOOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROTO_VER = 2'd2;
  localparam logic [7:0] PROTO_VER_RST = 8'd1;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // divide by 1000 as (n >> 3) / 125 through a reciprocal
  localparam int MUL_A_W = 29;
  localparam int MUL_B_W = 30;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam logic [MUL_B_W-1:0] AGE_RECIP = 30'd549755814;
  localparam int AGE_SHIFT = 36;
  localparam int AGE_Q_W = 23;
  localparam logic [MUL_B_W-1:0] MM_RECIP = 30'd4294968;
  localparam int MM_SHIFT = 29;
  localparam int MM_A_W = 22;

  localparam logic [31:0] ROUND_HALF = 32'd500;
  localparam logic [31:0] CLAMP_MAG = 32'd32768000;
  localparam logic [15:0] MM_MAX = 16'd32767;
  localparam logic [15:0] SENTINEL = 16'h8000;
  localparam logic [7:0] STALE_FULL = 8'd255;
  localparam logic [31:0] AGE_INVALID = 32'hFFFF_FFFF;

  localparam int DIV_STEPS = 9;
  localparam int DIV_CNT_W = 4;
  localparam int DIV_W = 40;

  localparam int LEFT_W = 4;
  localparam logic [LEFT_W-1:0] HDR_BYTES = 4'd7;
  localparam logic [LEFT_W-1:0] POS_BYTES = 4'd8;

  typedef enum logic {
    KIND_HEADER   = 1'b0,
    KIND_POSITION = 1'b1
  } psr_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_AGE,
    BK_STALE,
    BK_POS_X,
    BK_POS_Y,
    BK_POS_FIN,
    BK_EMIT
  } psr_back_state_t;

  typedef struct packed {
    logic [7:0]  conf_floor;
    logic [31:0] stale_thr;
    logic [7:0]  proto_ver;
  } psr_cfg_t;

  // classified item; mags are |coord| + 500
  typedef struct packed {
    psr_kind_t   kind;
    logic [7:0]  entry_count;
    logic        map_valid;
    logic        age_ok;
    logic [31:0] disturbance;
    logic [31:0] delta;
    logic [15:0] object_ident;
    logic        x_neg;
    logic [31:0] x_mag;
    logic        y_neg;
    logic [31:0] y_mag;
    logic [7:0]  compartment;
    logic [7:0]  confidence;
  } psr_entry_t;

  typedef struct packed {
    logic        start;
    logic [31:0] disturb;
    logic [31:0] thr;
  } psr_div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] stale;
  } psr_div_rsp_t;

endpackage

@@ rtl/psr_front.sv @@
module psr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [psr_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  output logic                             push_valid,
  input  logic                             push_ready,
  output psr_pkg::psr_entry_t              push_entry
);

  logic                fv_r;
  psr_pkg::psr_entry_t ent_r;
  psr_pkg::psr_entry_t ent_nxt;
  logic [31:0]         x_raw;
  logic [31:0]         y_raw;
  logic [32:0]         diff;

  assign in_tready  = !fv_r || push_ready;
  assign push_valid = fv_r;
  assign push_entry = ent_r;

  assign x_raw = in_tdata[psr_pkg::X_LSB +: 32];
  assign y_raw = in_tdata[psr_pkg::Y_LSB +: 32];
  assign diff  = {1'b0, in_tdata[psr_pkg::NOW_LSB +: 32]}
               - {1'b0, in_tdata[psr_pkg::MEAS_LSB +: 32]};

  always_comb begin
    ent_nxt              = '0;
    ent_nxt.kind         = psr_pkg::psr_kind_t'(in_tuser);
    ent_nxt.entry_count  = in_tdata[psr_pkg::CNT_LSB +: 8];
    ent_nxt.map_valid    = in_tdata[psr_pkg::MAPV_BIT];
    ent_nxt.age_ok       = in_tdata[psr_pkg::MAPV_BIT] && !diff[32];
    ent_nxt.disturbance  = in_tdata[psr_pkg::DIST_LSB +: 32];
    ent_nxt.delta        = diff[31:0];
    ent_nxt.object_ident = in_tdata[psr_pkg::IDENT_LSB +: 16];
    ent_nxt.compartment  = in_tdata[psr_pkg::COMP_LSB +: 8];
    ent_nxt.confidence   = in_tdata[psr_pkg::CONF_LSB +: 8];
    // |v| + 500 in one add: for negative v it is ~v + 501
    ent_nxt.x_neg        = x_raw[31];
    ent_nxt.x_mag        = (x_raw[31] ? ~x_raw : x_raw) + psr_pkg::ROUND_HALF
                         + 32'(x_raw[31]);
    ent_nxt.y_neg        = y_raw[31];
    ent_nxt.y_mag        = (y_raw[31] ? ~y_raw : y_raw) + psr_pkg::ROUND_HALF
                         + 32'(y_raw[31]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      fv_r <= 1'b1;
    end else if (push_ready) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

@@ rtl/psr_queue.sv @@
module psr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  psr_pkg::psr_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output psr_pkg::psr_entry_t pop_entry
);

  psr_pkg::psr_entry_t       mem_r [psr_pkg::QDEPTH];
  logic [psr_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [psr_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [psr_pkg::QPTR_W:0]   count_r;
  logic                       push;
  logic                       pop;

  assign push_ready = count_r != (psr_pkg::QPTR_W + 1)'(psr_pkg::QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_entry  = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + psr_pkg::QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + psr_pkg::QPTR_W'(1);
      if (push && !pop) begin
        count_r <= count_r + (psr_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (psr_pkg::QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (psr_pkg::QPTR_W + 1)'(psr_pkg::QDEPTH))
    else $error("queue count past depth");

endmodule

@@ rtl/psr_div.sv @@
module psr_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psr_pkg::psr_div_req_t req,
  output psr_pkg::psr_div_rsp_t rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic                          zero_r;
  logic [psr_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [psr_pkg::DIV_W-1:0]     rem_r;
  logic [psr_pkg::DIV_W-1:0]     dv_r;
  logic [psr_pkg::DIV_STEPS-1:0] q_r;
  logic                          ge;

  assign ge = rem_r >= dv_r;

  // one quotient bit a cycle, divisor starting at thr << 8; bit 8 set means >= 256
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r &&
                   cnt_r == psr_pkg::DIV_CNT_W'(psr_pkg::DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      // disturbance * 255 as (d << 8) - d
      rem_r  <= {req.disturb, 8'h00} - {8'h00, req.disturb};
      dv_r   <= {req.thr, 8'h00};
      q_r    <= '0;
      cnt_r  <= '0;
      zero_r <= req.thr == '0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dv_r;
      q_r   <= {q_r[psr_pkg::DIV_STEPS-2:0], ge};
      dv_r  <= dv_r >> 1;
      cnt_r <= cnt_r + psr_pkg::DIV_CNT_W'(1);
    end
  end

  assign rsp.done  = done_r;
  assign rsp.stale = zero_r ? 8'h00
                   : (q_r[psr_pkg::DIV_STEPS-1] ? psr_pkg::STALE_FULL : q_r[7:0]);

endmodule

@@ rtl/psr_back.sv @@
module psr_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  psr_pkg::psr_cfg_t                  cfg,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  psr_pkg::psr_entry_t                pop_entry,
  output psr_pkg::psr_div_req_t              div_req,
  input  psr_pkg::psr_div_rsp_t              div_rsp,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [psr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast
);

  psr_pkg::psr_back_state_t  state_r;
  psr_pkg::psr_back_state_t  state_nxt;
  psr_pkg::psr_entry_t       cur_r;
  logic [psr_pkg::PROD_W-1:0] prod_r;
  logic [15:0]               x_mm_r;
  logic [63:0]               rec_r;
  logic [psr_pkg::LEFT_W-1:0] left_r;
  logic                      suppress_r;

  logic                       take;
  logic                       mul_en;
  logic                       mul_age;
  logic                       stage_x;
  logic                       load_hdr;
  logic                       load_pos;
  logic                       fin_y;
  logic [31:0]                sel_mag;
  logic [psr_pkg::MUL_A_W-1:0] mul_a;
  logic [psr_pkg::MUL_B_W-1:0] mul_b;
  logic [psr_pkg::PROD_W-1:0]  prod_nxt;
  logic [31:0]                fin_mag;
  logic                       fin_neg;
  logic [15:0]                mm_mag;
  logic [15:0]                mm_val;
  logic                       withhold;
  logic [15:0]                x_out;
  logic [15:0]                y_out;
  logic [7:0]                 stale;
  logic [31:0]                age;
  logic [63:0]                hdr_rec;
  logic [63:0]                pos_rec;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psr_pkg::BK_IDLE: begin
        if (pop_valid) begin
          state_nxt = (pop_entry.kind == psr_pkg::KIND_HEADER) ? psr_pkg::BK_AGE
                                                               : psr_pkg::BK_POS_X;
        end
      end
      psr_pkg::BK_AGE:     state_nxt = psr_pkg::BK_STALE;
      psr_pkg::BK_STALE: begin
        if (div_rsp.done) state_nxt = psr_pkg::BK_EMIT;
      end
      psr_pkg::BK_POS_X:   state_nxt = psr_pkg::BK_POS_Y;
      psr_pkg::BK_POS_Y:   state_nxt = psr_pkg::BK_POS_FIN;
      psr_pkg::BK_POS_FIN: state_nxt = psr_pkg::BK_EMIT;
      psr_pkg::BK_EMIT: begin
        if (out_tready && left_r == psr_pkg::LEFT_W'(1)) state_nxt = psr_pkg::BK_IDLE;
      end
      default:             state_nxt = psr_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_ready  = 1'b0;
    mul_en     = 1'b0;
    mul_age    = 1'b0;
    stage_x    = 1'b0;
    load_hdr   = 1'b0;
    load_pos   = 1'b0;
    fin_y      = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      psr_pkg::BK_IDLE:    pop_ready = 1'b1;
      psr_pkg::BK_AGE: begin
        mul_en  = 1'b1;
        mul_age = 1'b1;
      end
      psr_pkg::BK_STALE:   load_hdr = div_rsp.done;
      psr_pkg::BK_POS_X:   mul_en = 1'b1;
      psr_pkg::BK_POS_Y: begin
        mul_en  = 1'b1;
        stage_x = 1'b1;
        fin_y   = 1'b1;
      end
      psr_pkg::BK_POS_FIN: load_pos = 1'b1;
      psr_pkg::BK_EMIT:    out_tvalid = 1'b1;
      default:             pop_ready = 1'b0;
    endcase
  end

  assign take            = pop_valid && pop_ready;
  assign div_req.start   = take && pop_entry.kind == psr_pkg::KIND_HEADER;
  assign div_req.disturb = pop_entry.disturbance;
  assign div_req.thr     = cfg.stale_thr;

  // one shared multiplier: age / 1000 or a coordinate / 1000
  assign sel_mag = fin_y ? cur_r.y_mag : cur_r.x_mag;

  always_comb begin
    if (mul_age) begin
      mul_a = cur_r.delta[31:3];
      mul_b = psr_pkg::AGE_RECIP;
    end else begin
      mul_a = psr_pkg::MUL_A_W'(sel_mag[psr_pkg::MM_A_W+2:3]);
      mul_b = psr_pkg::MM_RECIP;
    end
  end
  assign prod_nxt = {{psr_pkg::MUL_B_W{1'b0}}, mul_a}
                  * {{psr_pkg::MUL_A_W{1'b0}}, mul_b};

  // finish a coordinate from the registered product: x in POS_Y, y in POS_FIN
  assign fin_mag = load_pos ? cur_r.y_mag : cur_r.x_mag;
  assign fin_neg = load_pos ? cur_r.y_neg : cur_r.x_neg;
  assign mm_mag  = (fin_mag >= psr_pkg::CLAMP_MAG) ? psr_pkg::MM_MAX
                                                   : prod_r[psr_pkg::MM_SHIFT +: 16];
  assign mm_val  = fin_neg ? (16'h0000 - mm_mag) : mm_mag;

  assign withhold = suppress_r || (cur_r.confidence < cfg.conf_floor);
  assign x_out    = withhold ? psr_pkg::SENTINEL : x_mm_r;
  assign y_out    = withhold ? psr_pkg::SENTINEL : mm_val;
  assign pos_rec  = {cur_r.confidence, cur_r.compartment, y_out, x_out, cur_r.object_ident};

  assign stale   = cur_r.map_valid ? div_rsp.stale : psr_pkg::STALE_FULL;
  assign age     = cur_r.age_ok ? 32'(prod_r[psr_pkg::AGE_SHIFT +: psr_pkg::AGE_Q_W])
                                : psr_pkg::AGE_INVALID;
  assign hdr_rec = {8'h00, age, stale, cur_r.entry_count, cfg.proto_ver};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= psr_pkg::BK_IDLE;
      left_r     <= '0;
      suppress_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_hdr) begin
        left_r     <= psr_pkg::HDR_BYTES;
        suppress_r <= stale == psr_pkg::STALE_FULL;
      end else if (load_pos) begin
        left_r <= psr_pkg::POS_BYTES;
      end else if (out_tvalid && out_tready) begin
        left_r <= left_r - psr_pkg::LEFT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take)    cur_r  <= pop_entry;
    if (mul_en)  prod_r <= prod_nxt;
    if (stage_x) x_mm_r <= mm_val;
    if (load_hdr) begin
      rec_r <= hdr_rec;
    end else if (load_pos) begin
      rec_r <= pos_rec;
    end else if (out_tvalid && out_tready) begin
      rec_r <= rec_r >> 8;
    end
  end

  assign out_tdata = rec_r[7:0];
  assign out_tlast = left_r == psr_pkg::LEFT_W'(1);

  a_div_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == psr_pkg::BK_STALE)
    else $error("divider finished while back end was not waiting");

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (left_r != '0 && left_r <= psr_pkg::POS_BYTES))
    else $error("byte count out of range during emission");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("record continued past its last byte");

  a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_tvalid) && cur_r.kind == psr_pkg::KIND_HEADER)
      |-> left_r == psr_pkg::HDR_BYTES)
    else $error("header record does not start with seven bytes");

endmodule

@@ rtl/position_report_serializer.sv @@
// Position report serializer.
// Input channel: one item per report record. in_tuser selects the kind
// (0 header, 1 position entry); in_tdata carries all item fields. A header
// becomes 7 little-endian bytes (version, count, staleness, age in s), a
// position entry 8 bytes (ident, x mm, y mm, compartment, confidence).
// Output channel: one byte per transfer on out_tdata, out_tlast on the final
// byte of each record.
// Config channel: cfg_index 0 confidence floor, 1 stale threshold,
// 2 protocol version; always ready, write only while the block is idle.
// A position entry is popped, passes the POS_X, POS_Y and POS_FIN
// multiply/finish states, then its 8 bytes are emitted. A header is popped,
// its age is multiplied in BK_AGE, and the staleness divider resolves one
// bit a cycle over 9 steps before its 7 bytes are emitted.
// Items pass a front register and a two-entry queue, so up to three items
// are taken while a record still waits on the output. A stalled receiver
// holds the current byte; the queue then fills and in_tready drops.
// Reset clears the queue, the staleness flag and the config registers to
// floor 0, threshold 0, version 1.
module position_report_serializer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] entry_count, [8] map_valid, [40:9] disturbance, [72:41] measured_at,
  // [104:73] now_time, [120:105] object_ident, [152:121] x_micro,
  // [184:153] y_micro, [192:185] compartment, [200:193] confidence, rest zero
  input  logic [psr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] cmd
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] out_byte
  output logic [psr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  psr_pkg::psr_cfg_t     cfg_r;
  logic                  push_valid;
  logic                  push_ready;
  psr_pkg::psr_entry_t   push_entry;
  logic                  pop_valid;
  logic                  pop_ready;
  psr_pkg::psr_entry_t   pop_entry;
  psr_pkg::psr_div_req_t div_req;
  psr_pkg::psr_div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.conf_floor <= '0;
      cfg_r.stale_thr  <= '0;
      cfg_r.proto_ver  <= psr_pkg::PROTO_VER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psr_pkg::REG_CONF_FLOOR: cfg_r.conf_floor <= cfg_data[7:0];
        psr_pkg::REG_STALE_THR:  cfg_r.stale_thr  <= cfg_data;
        psr_pkg::REG_PROTO_VER:  cfg_r.proto_ver  <= cfg_data[7:0];
        default:                 cfg_r.proto_ver  <= cfg_r.proto_ver;
      endcase
    end
  end

  psr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  psr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  psr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  psr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
